>>> rtl/tlik_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and datapath step functions for the three-link arm IK block.
// No dependencies.
package tlik_pkg;

   localparam int UPPER_ARM_LENGTH = 5376;
   localparam int FOREARM_LENGTH   = 4352;
   localparam int HAND_LENGTH      = 3149;

   localparam int ANGLE_W   = 16;
   localparam int COORD_W   = 16;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NEG_Z = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FAIL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_MAX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SHOULDER_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHOULDER_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ELBOW_MIN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ELBOW_MAX    = 3'd5;

   localparam logic signed [15:0] BASE_MIN_RST     = -16'sd1920;
   localparam logic signed [15:0] BASE_MAX_RST     = 16'sd13440;
   localparam logic signed [15:0] SHOULDER_MIN_RST = 16'sd640;
   localparam logic signed [15:0] SHOULDER_MAX_RST = 16'sd21120;
   localparam logic signed [15:0] ELBOW_MIN_RST    = 16'sd640;
   localparam logic signed [15:0] ELBOW_MAX_RST    = 16'sd21120;

   // derived link constants
   localparam logic signed [16:0] L0_S17  = 17'(UPPER_ARM_LENGTH);
   localparam logic signed [35:0] L0_S36  = 36'(UPPER_ARM_LENGTH);
   localparam logic signed [34:0] L1SQ_S  = 35'(FOREARM_LENGTH * FOREARM_LENGTH);
   localparam logic signed [34:0] L2SQ_S  = 35'(HAND_LENGTH * HAND_LENGTH);
   localparam logic [30:0]        K4L1SQ  = 31'(4 * FOREARM_LENGTH * FOREARM_LENGTH);
   localparam logic [63:0]        D2L1L2  = 64'(2 * FOREARM_LENGTH * HAND_LENGTH);
   localparam logic [63:0]        DEN2C   = D2L1L2 * D2L1L2;

   localparam int SQ_STEPS = 32;

   // angles in 2^-16 degree
   localparam logic signed [26:0] DEG90   = 27'sd5898240;
   localparam logic signed [26:0] DEG360  = 27'sd23592960;
   localparam logic signed [26:0] RND_64TH = 27'sd512;
   // angles in 1/64 degree
   localparam logic signed [17:0] HALF_TURN = 18'sd11520;
   localparam logic signed [17:0] MIRROR    = 18'sd23040;

   localparam logic signed [26:0] ATAN_TAB [0:23] = '{
      27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379, 27'sd117300,
      27'sd58666, 27'sd29335, 27'sd14668, 27'sd7334, 27'sd3667, 27'sd1833,
      27'sd917, 27'sd458, 27'sd229, 27'sd115, 27'sd57, 27'sd29,
      27'sd14, 27'sd7, 27'sd4, 27'sd2, 27'sd1, 27'sd0
   };

   typedef struct packed {
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [26:0] acc;
   } cordic_type;

   typedef struct packed {
      logic [63:0] rad;
      logic [35:0] rem;
      logic [31:0] root;
   } sqrt_type;

   typedef struct packed {
      logic neg_z;
      logic fail;
      logic x_zero;
      logic x_neg;
      logic y_neg;
   } flag_type;

   typedef struct packed {
      flag_type           flags;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic signed [34:0] n1;
      logic signed [34:0] n2;
   } meta_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [ANGLE_W-1:0] base;
      logic signed [ANGLE_W-1:0] shoulder;
      logic signed [ANGLE_W-1:0] elbow;
   } rsp_type;

   // one digit of a restoring square root, two radicand bits per step
   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type    r;
      logic [35:0] cur;
      logic [35:0] trial;
      cur   = {s.rem[33:0], s.rad[63:62]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[61:0], 2'b00};
      if (cur >= trial) begin
         r.rem  = cur - trial;
         r.root = {s.root[30:0], 1'b1};
      end else begin
         r.rem  = cur;
         r.root = {s.root[30:0], 1'b0};
      end
      return r;
   endfunction

   // quadrant fold into the right half plane
   function automatic cordic_type cordic_pre(input logic signed [35:0] y,
                                             input logic signed [35:0] x);
      cordic_type r;
      r.x   = x;
      r.y   = y;
      r.acc = 27'sd0;
      if (x < 36'sd0) begin
         if (y >= 36'sd0) begin
            r.x   = y;
            r.y   = -x;
            r.acc = DEG90;
         end else begin
            r.x   = -y;
            r.y   = x;
            r.acc = -DEG90;
         end
      end
      return r;
   endfunction

   function automatic cordic_type cordic_step(input cordic_type s, input logic [4:0] i);
      cordic_type         r;
      logic signed [35:0] dx;
      logic signed [35:0] dy;
      dx = s.y >>> i;
      dy = s.x >>> i;
      if (s.y > 36'sd0) begin
         r.x   = s.x + dx;
         r.y   = s.y - dy;
         r.acc = s.acc + ATAN_TAB[i];
      end else begin
         r.x   = s.x - dx;
         r.y   = s.y + dy;
         r.acc = s.acc - ATAN_TAB[i];
      end
      return r;
   endfunction

endpackage

>>> rtl/tlik_if.sv
`timescale 1ns / 1ps
// Channel interfaces: target request, joint-angle response, register write port.
// Depends on tlik_pkg for field widths.
interface tlik_req_if import tlik_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] target_x;
   logic signed [COORD_W-1:0] target_y;
   logic signed [COORD_W-1:0] target_z;
   modport source (output valid, target_x, target_y, target_z, input ready);
   modport sink   (input valid, target_x, target_y, target_z, output ready);
endinterface

interface tlik_rsp_if import tlik_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [ANGLE_W-1:0] base_angle;
   logic signed [ANGLE_W-1:0] shoulder_angle;
   logic signed [ANGLE_W-1:0] elbow_angle;
   modport source (output valid, status, base_angle, shoulder_angle, elbow_angle,
                   input ready);
   modport sink   (input valid, status, base_angle, shoulder_angle, elbow_angle,
                   output ready);
endinterface

interface tlik_csr_if import tlik_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/three_link_arm_inverse_kinematics_top.sv
`timescale 1ns / 1ps
// Three-link arm inverse kinematics: target point in, base/shoulder/elbow angles out.
// Depends on tlik_pkg and the channel interfaces in tlik_if.sv.
//
// Usage
//   req_ch : one target point (x, y, z, 1/256 length unit) per transaction.
//   rsp_ch : one result per request, in order: status and three angles in
//            1/64 degree. Angles are zero unless status is ok.
//   csr_ch : joint limit writes, index 0..5 (base, shoulder, elbow min/max).
//            Always ready; indexes 6 and 7 are dropped. Write only when idle.
// Throughput: one transaction per cycle while the skid register is empty.
// Pipeline: the 32-digit square-root chain and the CORDIC vectoring chain,
//   one digit or one rotation per stage, plus nine stages of setup, rounding
//   and limit checking.
// Stall: the whole pipeline advances together. A result that the receiver
//   does not take drops into a one-entry skid register; while that register
//   is full the pipeline holds and req_ch.ready is low. Nothing is lost or
//   repeated.
// Reset: synchronous, clears all valid bits and the skid, loads the default
//   joint limits. No clearing pass is needed.
module three_link_arm_inverse_kinematics_top
   import tlik_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input logic        clock,
   input logic        reset,
   tlik_req_if.sink   req_ch,
   tlik_rsp_if.source rsp_ch,
   tlik_csr_if.sink   csr_ch
);

   localparam int CS = CORDIC_STAGES;

   // ---------------------------------------------------------------- limits
   logic signed [15:0] bmin_ff, bmax_ff, smin_ff, smax_ff, emin_ff, emax_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bmin_ff <= BASE_MIN_RST;
         bmax_ff <= BASE_MAX_RST;
         smin_ff <= SHOULDER_MIN_RST;
         smax_ff <= SHOULDER_MAX_RST;
         emin_ff <= ELBOW_MIN_RST;
         emax_ff <= ELBOW_MAX_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_BASE_MIN:     bmin_ff <= $signed(csr_ch.data);
            REG_BASE_MAX:     bmax_ff <= $signed(csr_ch.data);
            REG_SHOULDER_MIN: smin_ff <= $signed(csr_ch.data);
            REG_SHOULDER_MAX: smax_ff <= $signed(csr_ch.data);
            REG_ELBOW_MIN:    emin_ff <= $signed(csr_ch.data);
            REG_ELBOW_MAX:    emax_ff <= $signed(csr_ch.data);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- flow control
   logic    skid_full_ff;
   rsp_type skid_ff;
   logic    last_v_ff;
   rsp_type last_ff;
   logic    adv;

   assign adv          = !skid_full_ff;
   assign req_ch.ready = adv;

   // ------------------------------------------------ stage 1: capture input
   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [15:0] x1_ff, y1_ff, z1_ff;

   // ---------------------------------------- stage 2: squares of the target
   logic signed [31:0] px, py;
   logic signed [16:0] dz;
   logic signed [33:0] dz_sq;
   logic [31:0]        c2_in;
   logic signed [15:0] x2_ff, y2_ff, z2_ff;
   logic [31:0]        c2_2_ff, dz2_2_ff;

   assign px    = x1_ff * x1_ff;
   assign py    = y1_ff * y1_ff;
   assign c2_in = $unsigned(px) + $unsigned(py);
   assign dz    = {z1_ff[15], z1_ff} - L0_S17;
   assign dz_sq = dz * dz;

   // ------------------------- stage 3: b squared, law of cosines numerators
   logic [32:0]        b2_in;
   logic signed [34:0] n1_in, n2_in;
   meta_type           m3_in;
   meta_type           m3_ff, m4_ff, m5_ff;
   logic [32:0]        b2_3_ff;
   logic [31:0]        c2_3_ff, c2_4_ff, c2_5_ff;

   always_comb begin
      b2_in = {1'b0, c2_2_ff} + {1'b0, dz2_2_ff};
      n1_in = $signed({2'b00, b2_in}) + L1SQ_S - L2SQ_S;
      n2_in = L1SQ_S + L2SQ_S - $signed({2'b00, b2_in});
      m3_in.flags.neg_z  = z2_ff[15];
      // origin or shoulder joint itself
      m3_in.flags.fail   = ((c2_2_ff == 32'd0) && (z2_ff == 16'sd0)) || (b2_in == 33'd0);
      m3_in.flags.x_zero = (x2_ff == 16'sd0);
      m3_in.flags.x_neg  = x2_ff[15];
      m3_in.flags.y_neg  = y2_ff[15];
      m3_in.x  = x2_ff;
      m3_in.y  = y2_ff;
      m3_in.z  = z2_ff;
      m3_in.n1 = n1_in;
      m3_in.n2 = n2_in;
   end

   // ------------------------ stage 4: denominator and numerator magnitudes
   logic [63:0] den2_in;
   logic [33:0] mag1_in, mag2_in;
   logic [63:0] den2_4_ff, den2_5_ff;
   logic [33:0] mag1_4_ff, mag2_4_ff;

   assign den2_in = b2_3_ff * K4L1SQ;
   assign mag1_in = m3_ff.n1[34] ? 34'(-m3_ff.n1) : 34'(m3_ff.n1);
   assign mag2_in = m3_ff.n2[34] ? 34'(-m3_ff.n2) : 34'(m3_ff.n2);

   // ---------------------------------------- stage 5: numerator squares
   logic [63:0] sq1_in, sq2_in;
   logic [63:0] sq1_5_ff, sq2_5_ff;
   logic        big1_5_ff, big2_5_ff;

   assign sq1_in = mag1_4_ff[31:0] * mag1_4_ff[31:0];
   assign sq2_in = mag2_4_ff[31:0] * mag2_4_ff[31:0];

   // ------------- stage 6: cosine range checks, radicands into sqrt chain
   logic     f1, f2;
   meta_type m6_in;
   sqrt_type sq0_in [0:2];

   logic     sqv_ff [0:SQ_STEPS];
   meta_type sqm_ff [0:SQ_STEPS];
   sqrt_type sqs_ff [0:SQ_STEPS][0:2];

   always_comb begin
      f1 = big1_5_ff || (sq1_5_ff > den2_5_ff) || (den2_5_ff == 64'd0);
      f2 = big2_5_ff || (sq2_5_ff > DEN2C);
      m6_in = m5_ff;
      m6_in.flags.fail = m5_ff.flags.fail || f1 || f2;
      sq0_in[0] = '{rad: {16'd0, c2_5_ff, 16'd0}, rem: 36'd0, root: 32'd0};
      sq0_in[1] = '{rad: den2_5_ff - sq1_5_ff, rem: 36'd0, root: 32'd0};
      sq0_in[2] = '{rad: DEN2C - sq2_5_ff, rem: 36'd0, root: 32'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         v5_ff     <= 1'b0;
         sqv_ff[0] <= 1'b0;
      end else if (adv) begin
         v1_ff     <= req_ch.valid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         v5_ff     <= v4_ff;
         sqv_ff[0] <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff     <= req_ch.target_x;
         y1_ff     <= req_ch.target_y;
         z1_ff     <= req_ch.target_z;
         x2_ff     <= x1_ff;
         y2_ff     <= y1_ff;
         z2_ff     <= z1_ff;
         c2_2_ff   <= c2_in;
         dz2_2_ff  <= dz_sq[31:0];
         m3_ff     <= m3_in;
         b2_3_ff   <= b2_in;
         c2_3_ff   <= c2_2_ff;
         m4_ff     <= m3_ff;
         den2_4_ff <= den2_in;
         mag1_4_ff <= mag1_in;
         mag2_4_ff <= mag2_in;
         c2_4_ff   <= c2_3_ff;
         m5_ff     <= m4_ff;
         den2_5_ff <= den2_4_ff;
         sq1_5_ff  <= sq1_in;
         sq2_5_ff  <= sq2_in;
         big1_5_ff <= |mag1_4_ff[33:32];
         big2_5_ff <= |mag2_4_ff[33:32];
         c2_5_ff   <= c2_4_ff;
         sqm_ff[0] <= m6_in;
         for (int u = 0; u < 3; u++) begin
            sqs_ff[0][u] <= sq0_in[u];
         end
      end
   end

   // ------------------------- square roots, one result bit per stage
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (reset) begin
            sqv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sqv_ff[k+1] <= sqv_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sqm_ff[k+1] <= sqm_ff[k];
            for (int u = 0; u < 3; u++) begin
               sqs_ff[k+1][u] <= sqrt_step(sqs_ff[k][u]);
            end
         end
      end
   end

   // ---- CORDIC vectoring: base, shoulder elevation, shoulder and elbow acos
   // unit 0 base atan2(y, x); unit 1 atan2(|xy|, l0 - z);
   // unit 2 and 3 acos as atan2(sqrt(d^2 - n^2), n)
   meta_type   mq;
   cordic_type cd0_in [0:3];

   logic       cdv_ff [0:CS];
   flag_type   cdf_ff [0:CS];
   cordic_type cds_ff [0:CS][0:3];

   always_comb begin
      mq = sqm_ff[SQ_STEPS];
      cd0_in[0] = cordic_pre(36'(mq.y) <<< 8, 36'(mq.x) <<< 8);
      cd0_in[1] = cordic_pre($signed({4'd0, sqs_ff[SQ_STEPS][0].root}),
                             (L0_S36 - 36'(mq.z)) <<< 8);
      cd0_in[2] = cordic_pre($signed({4'd0, sqs_ff[SQ_STEPS][1].root}), 36'(mq.n1));
      cd0_in[3] = cordic_pre($signed({4'd0, sqs_ff[SQ_STEPS][2].root}), 36'(mq.n2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cdv_ff[0] <= 1'b0;
      end else if (adv) begin
         cdv_ff[0] <= sqv_ff[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cdf_ff[0] <= mq.flags;
         for (int u = 0; u < 4; u++) begin
            cds_ff[0][u] <= cd0_in[u];
         end
      end
   end

   for (genvar i = 0; i < CS; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (reset) begin
            cdv_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cdv_ff[i+1] <= cdv_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            cdf_ff[i+1] <= cdf_ff[i];
            for (int u = 0; u < 4; u++) begin
               cds_ff[i+1][u] <= cordic_step(cds_ff[i][u], 5'(i));
            end
         end
      end
   end

   // ----------------------- rounding to 1/64 degree, base quadrant fix-up
   logic signed [26:0] base_adj, base_rnd, sh_rnd, el_rnd;
   logic signed [17:0] be_in, sh_in, el_in;
   logic               rd_v_ff;
   flag_type           rd_f_ff;
   logic signed [17:0] be_ff, sh_ff, el_ff;

   always_comb begin
      base_adj = cds_ff[CS][0].acc;
      if (cdf_ff[CS].x_neg && (base_adj < 27'sd0)) begin
         base_adj = base_adj + DEG360;
      end
      if (cdf_ff[CS].x_zero) begin
         base_adj = cdf_ff[CS].y_neg ? -DEG90 : DEG90;
      end
      base_rnd = base_adj + RND_64TH;
      sh_rnd   = cds_ff[CS][1].acc + cds_ff[CS][2].acc + RND_64TH;
      el_rnd   = cds_ff[CS][3].acc + RND_64TH;
      be_in    = 18'(base_rnd >>> 10);
      sh_in    = 18'(sh_rnd >>> 10);
      el_in    = 18'(el_rnd >>> 10);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else if (adv) begin
         rd_v_ff <= cdv_ff[CS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_f_ff <= cdf_ff[CS];
         be_ff   <= be_in;
         sh_ff   <= sh_in;
         el_ff   <= el_in;
      end
   end

   // ------------------------- joint limits, mirrored pose as a fallback
   function automatic logic in_lim(input logic signed [17:0] v,
                                   input logic signed [15:0] lo,
                                   input logic signed [15:0] hi);
      return (v >= 18'(lo)) && (v <= 18'(hi));
   endfunction

   rsp_type            res_in;
   logic signed [17:0] be_m, sh_m, el_m;

   always_comb begin
      res_in = '{status: STATUS_OK, base: 16'sd0, shoulder: 16'sd0, elbow: 16'sd0};
      be_m   = (be_ff < 18'(bmin_ff)) ? be_ff + HALF_TURN : be_ff - HALF_TURN;
      sh_m   = MIRROR - sh_ff;
      el_m   = MIRROR - el_ff;
      if (rd_f_ff.neg_z) begin
         res_in.status = STATUS_NEG_Z;
      end else if (rd_f_ff.fail || !in_lim(sh_ff, smin_ff, smax_ff) ||
                   !in_lim(el_ff, emin_ff, emax_ff)) begin
         res_in.status = STATUS_FAIL;
      end else if (in_lim(be_ff, bmin_ff, bmax_ff)) begin
         res_in.base     = be_ff[15:0];
         res_in.shoulder = sh_ff[15:0];
         res_in.elbow    = el_ff[15:0];
      end else if (in_lim(be_m, bmin_ff, bmax_ff) && in_lim(sh_m, smin_ff, smax_ff) &&
                   in_lim(el_m, emin_ff, emax_ff)) begin
         res_in.base     = be_m[15:0];
         res_in.shoulder = sh_m[15:0];
         res_in.elbow    = el_m[15:0];
      end else begin
         res_in.status = STATUS_FAIL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_v_ff <= 1'b0;
      end else if (adv) begin
         last_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff <= res_in;
      end
   end

   // ------------------------------------------------ output skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_ch.ready) begin
            skid_full_ff <= 1'b0;
         end
      end else if (last_v_ff && !rsp_ch.ready) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff && last_v_ff && !rsp_ch.ready) begin
         skid_ff <= last_ff;
      end
   end

   rsp_type rsp_sel;
   assign rsp_sel               = skid_full_ff ? skid_ff : last_ff;
   assign rsp_ch.valid          = skid_full_ff || last_v_ff;
   assign rsp_ch.status         = rsp_sel.status;
   assign rsp_ch.base_angle     = rsp_sel.base;
   assign rsp_ch.shoulder_angle = rsp_sel.shoulder;
   assign rsp_ch.elbow_angle    = rsp_sel.elbow;

   // ------------------------------------------------------------ assertions
   a_no_bad_status: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.status != 2'd3))
      else $error("reserved status code on response");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != STATUS_OK)) |->
      (rsp_ch.base_angle == 16'sd0 && rsp_ch.shoulder_angle == 16'sd0 &&
       rsp_ch.elbow_angle == 16'sd0))
      else $error("nonzero angles on failed transaction");

   a_ok_in_limits: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == STATUS_OK)) |->
      (rsp_ch.base_angle >= bmin_ff && rsp_ch.base_angle <= bmax_ff &&
       rsp_ch.shoulder_angle >= smin_ff && rsp_ch.shoulder_angle <= smax_ff &&
       rsp_ch.elbow_angle >= emin_ff && rsp_ch.elbow_angle <= emax_ff))
      else $error("ok transaction outside joint limits");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(last_v_ff && !rsp_ch.ready))
      else $error("skid filled without a stalled result");

endmodule
